/* rtl/r2zyz_pkg.sv */
// ----------------------------------------------------------------------------
// r2zyz_pkg
// Types, constants and helper functions for the rotation to ZYZ Euler block.
// ----------------------------------------------------------------------------
package r2zyz_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_ITERS  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int SQRT_BITS     = 30;
    localparam int CW            = 34;
    localparam int ZW            = 26;
    localparam int REM_W         = 61;

    localparam logic [14:0] ANGLE_MAX = 15'd18000;

    localparam logic [1:0] BR_GENERAL   = 2'd0;
    localparam logic [1:0] BR_NEAR_ZERO = 2'd1;
    localparam logic [1:0] BR_NEAR_180  = 2'd2;

    localparam logic signed [ZW-1:0] ATAN_DEG16 [24] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
        26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
        26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] phi_angle;
        logic        [14:0] theta_angle;
        logic signed [15:0] psi_angle;
        logic        [1:0]  branch_case;
    } t_out_item;

    function automatic logic signed [CW-1:0] scale_entry(input logic signed [15:0] v);
        return {{(CW-30){v[15]}}, v, 14'b0};
    endfunction

    function automatic logic signed [15:0] to_hundredths(input logic signed [ZW-1:0] z);
        logic [ZW-2:0] mag;
        logic [32:0]   p;
        logic [16:0]   q;
        logic [15:0]   h;
        mag = (z < 0) ? (ZW-1)'(-z) : (ZW-1)'(z);
        p   = 33'(mag) * 33'd100 + 33'd32768;
        q   = p[32:16];
        h   = (q > 17'(ANGLE_MAX)) ? 16'(ANGLE_MAX) : q[15:0];
        return (z < 0) ? -$signed(h) : $signed(h);
    endfunction

endpackage

/* rtl/r2zyz_cordic.sv */
// ----------------------------------------------------------------------------
// r2zyz_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees times 2^16.
// ----------------------------------------------------------------------------
module r2zyz_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [r2zyz_pkg::CW-1:0]      i_x,
    input  logic signed [r2zyz_pkg::CW-1:0]      i_y,
    output logic signed [r2zyz_pkg::ZW-1:0]      o_z
);

    localparam int N = r2zyz_pkg::CORDIC_ITERS;

    logic signed [r2zyz_pkg::CW-1:0] r_x [N+1];
    logic signed [r2zyz_pkg::CW-1:0] r_y [N+1];
    logic signed [r2zyz_pkg::ZW-1:0] r_z [N+1];
    logic                            r_zero [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= r2zyz_pkg::ZW'(90 * 65536);
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -r2zyz_pkg::ZW'(90 * 65536);
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + r2zyz_pkg::ATAN_DEG16[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - r2zyz_pkg::ATAN_DEG16[i];
                end
            end
        end
    end

    assign o_z = r_zero[N] ? '0 : r_z[N];

endmodule

/* rtl/rotation_to_zyz_euler.sv */
// ----------------------------------------------------------------------------
// rotation_to_zyz_euler
// Rotation matrix entries in Q2.14 to ZYZ Euler angles in hundredths of a
// degree, using an integer square root pipeline and four CORDIC pipelines.
//
//   channel   handshake             payload
//   input     i_valid / o_stall     i_item (r2zyz_pkg::t_in_item)
//   output    o_valid / i_stall     o_item (r2zyz_pkg::t_out_item)
//   config    i_cfg_we              i_cfg_data (degenerate threshold)
//
// One item is accepted per cycle while o_stall is low. The pipeline runs through the
// input register, squares, one square root bit per stage over 30 stages, CORDIC
// prerotation and iterations, rounding, and the output register.
// Reset clears all valid bits and sets the threshold to 1.
// A stall on the output while a result waits freezes the whole pipeline and
// raises o_stall.
// ----------------------------------------------------------------------------
module rotation_to_zyz_euler (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  r2zyz_pkg::t_in_item     i_item,
    output logic                    o_valid,
    input  logic                    i_stall,
    output r2zyz_pkg::t_out_item    o_item,
    input  logic                    i_cfg_we,
    input  logic [9:0]              i_cfg_data
);

    localparam int QB = r2zyz_pkg::SQRT_BITS;
    localparam int N  = r2zyz_pkg::CORDIC_ITERS;
    localparam int RW = r2zyz_pkg::REM_W;

    logic en;
    logic [9:0] r_thr;

    logic                 r_v0;
    r2zyz_pkg::t_in_item  r_in0;
    logic                 r_v1;
    r2zyz_pkg::t_in_item  r_in1;
    logic [31:0]          r_sq;

    logic                 r_vs   [QB];
    r2zyz_pkg::t_in_item  r_ins  [QB];
    logic [RW-1:0]        r_rem  [QB];
    logic [QB-1:0]        r_root [QB];

    logic                 r_vc [N+1];

    logic signed [r2zyz_pkg::ZW-1:0] z_theta, z_a, z_b, z_c;

    logic               r_vh;
    logic signed [15:0] r_h_theta, r_h_a, r_h_b, r_h_c;

    logic                 r_ov;
    r2zyz_pkg::t_out_item r_out;
    r2zyz_pkg::t_out_item n_out;
    logic [14:0]          theta_c;

    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 10'd1;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in0 <= i_item;
            r_in1 <= r_in0;
            r_sq  <= 32'(32'(r_in0.r20) * 32'(r_in0.r20))
                   + 32'(32'(r_in0.r21) * 32'(r_in0.r21));
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_sqrt
        localparam int B = QB - 1 - k;
        logic                 pv;
        r2zyz_pkg::t_in_item  pin;
        logic [RW-1:0]        prem;
        logic [QB-1:0]        proot;
        logic [RW-1:0]        trial;
        if (k == 0) begin : g_first
            assign pv    = r_v1;
            assign pin   = r_in1;
            assign prem  = RW'({r_sq, 28'b0});
            assign proot = '0;
        end else begin : g_next
            assign pv    = r_vs[k-1];
            assign pin   = r_ins[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
        end
        assign trial = (RW'(proot) << (B + 1)) + (RW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[k] <= 1'b0;
            end else if (en) begin
                r_vs[k] <= pv;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ins[k] <= pin;
                if (prem >= trial) begin
                    r_rem[k]  <= prem - trial;
                    r_root[k] <= proot | (QB'(1) << B);
                end else begin
                    r_rem[k]  <= prem;
                    r_root[k] <= proot;
                end
            end
        end
    end

    for (genvar j = 0; j <= N; j++) begin : g_cvalid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vc[j] <= 1'b0;
            end else if (en) begin
                r_vc[j] <= (j == 0) ? r_vs[QB-1] : r_vc[(j == 0) ? 0 : j-1];
            end
        end
    end

    r2zyz_cordic u_theta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r2zyz_pkg::scale_entry(r_ins[QB-1].r22)),
        .i_y   (r2zyz_pkg::CW'(r_root[QB-1])),
        .o_z   (z_theta)
    );

    r2zyz_cordic u_phi_lock (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r2zyz_pkg::scale_entry(r_ins[QB-1].r00)),
        .i_y   (r2zyz_pkg::scale_entry(r_ins[QB-1].r01)),
        .o_z   (z_a)
    );

    r2zyz_cordic u_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r2zyz_pkg::scale_entry(r_ins[QB-1].r20)),
        .i_y   (r2zyz_pkg::scale_entry(r_ins[QB-1].r21)),
        .o_z   (z_b)
    );

    r2zyz_cordic u_psi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (-r2zyz_pkg::scale_entry(r_ins[QB-1].r02)),
        .i_y   (r2zyz_pkg::scale_entry(r_ins[QB-1].r12)),
        .o_z   (z_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vh <= r_vc[N];
            r_ov <= r_vh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_theta <= r2zyz_pkg::to_hundredths(z_theta);
            r_h_a     <= r2zyz_pkg::to_hundredths(z_a);
            r_h_b     <= r2zyz_pkg::to_hundredths(z_b);
            r_h_c     <= r2zyz_pkg::to_hundredths(z_c);
            r_out     <= n_out;
        end
    end

    always_comb begin
        theta_c = (r_h_theta < 0) ? 15'd0 : r_h_theta[14:0];
        n_out.theta_angle = theta_c;
        if (theta_c < 15'(r_thr)) begin
            n_out.phi_angle   = r_h_a;
            n_out.psi_angle   = '0;
            n_out.branch_case = r2zyz_pkg::BR_NEAR_ZERO;
        end else if (theta_c > r2zyz_pkg::ANGLE_MAX - 15'(r_thr)) begin
            n_out.phi_angle   = -r_h_a;
            n_out.psi_angle   = '0;
            n_out.branch_case = r2zyz_pkg::BR_NEAR_180;
        end else begin
            n_out.phi_angle   = r_h_b;
            n_out.psi_angle   = r_h_c;
            n_out.branch_case = r2zyz_pkg::BR_GENERAL;
        end
    end

`ifndef SYNTH
    a_case_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.branch_case == r2zyz_pkg::BR_GENERAL ||
                     o_item.branch_case == r2zyz_pkg::BR_NEAR_ZERO ||
                     o_item.branch_case == r2zyz_pkg::BR_NEAR_180))
        else $error("invalid branch code");
    a_psi_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.branch_case != r2zyz_pkg::BR_GENERAL) |-> o_item.psi_angle == '0)
        else $error("psi nonzero in gimbal lock");
    a_theta_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.theta_angle <= r2zyz_pkg::ANGLE_MAX)
        else $error("theta out of range");
`endif

endmodule
